// ===== hdl/tsg_pkg.sv =====
`timescale 1ns / 1ps
package tsg_pkg;

   // Fixed point
   localparam int FractionBitsDefault = 16;
   localparam int TableBits           = 30;
   localparam int CoordWidth          = 32;
   localparam int HeadingUnits        = 24;
   localparam int HeadingWidth        = 5;

   // Queue between front and back
   localparam int QueueDepth = 4;

   // Symbols
   localparam logic [7:0] SymTurnLeft  = 8'h49;
   localparam logic [7:0] SymTurnRight = 8'h44;

   typedef enum logic [1:0] {
      MODE_DRAGON     = 2'd0,
      MODE_LEVY       = 2'd1,
      MODE_SIERPINSKI = 2'd2,
      MODE_NONE       = 2'd3
   } mode_type;

   // One classified symbol on its way to the back end
   typedef struct packed {
      logic                           restart;
      mode_type                       mode;
      logic                           emit;
      logic signed [CoordWidth-1:0]   dx;
      logic signed [CoordWidth-1:0]   dy;
   } step_type;

   // cos(k * 15 deg) in Q2.30, k = 0..6
   function automatic longint quarter_cos(input int k);
      longint v;
      case (k)
         0: v = 64'sd1073741824;
         1: v = 64'sd1037154959;
         2: v = 64'sd929887697;
         3: v = 64'sd759250125;
         4: v = 64'sd536870912;
         5: v = 64'sd277904834;
         default: v = 64'sd0;
      endcase
      return v;
   endfunction

   function automatic longint cos_q30(input int k);
      longint v;
      if (k <= 6) v = quarter_cos(k);
      else if (k <= 12) v = -quarter_cos(12 - k);
      else if (k <= 18) v = -quarter_cos(k - 12);
      else v = quarter_cos(24 - k);
      return v;
   endfunction

   function automatic longint step_len(input int m);
      longint v;
      case (m)
         0: v = 64'sd5;
         1: v = 64'sd8;
         2: v = 64'sd2;
         default: v = 64'sd0;
      endcase
      return v;
   endfunction

   function automatic logic [HeadingWidth-1:0] turn_units(input mode_type m);
      logic [HeadingWidth-1:0] v;
      case (m)
         MODE_DRAGON:     v = HeadingWidth'(6);
         MODE_LEVY:       v = HeadingWidth'(3);
         MODE_SIERPINSKI: v = HeadingWidth'(4);
         default:         v = HeadingWidth'(0);
      endcase
      return v;
   endfunction

   // Step displacement along one axis, rounded to frac bits, ties away from zero.
   // Only called with constant arguments.
   function automatic logic signed [CoordWidth-1:0] step_disp(
      input int m, input int d, input bit y_axis, input int frac);
      longint q;
      longint p;
      longint mag;
      int     k;
      int     sh;
      bit     neg;
      k   = y_axis ? ((d + 18) % HeadingUnits) : d;
      q   = cos_q30(k);
      p   = step_len(m) * q;
      neg = (p < 0);
      mag = neg ? -p : p;
      sh  = TableBits - frac;
      mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      if (neg) mag = -mag;
      if (y_axis) mag = -mag;
      return CoordWidth'(mag);
   endfunction

   function automatic logic signed [CoordWidth-1:0] sat_coord(input longint v);
      logic signed [CoordWidth-1:0] r;
      if (v > 64'sd2147483647) r = {1'b0, {(CoordWidth-1){1'b1}}};
      else if (v < -64'sd2147483648) r = {1'b1, {(CoordWidth-1){1'b0}}};
      else r = CoordWidth'(v);
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] origin_x(input mode_type m,
                                                             input int frac);
      logic signed [CoordWidth-1:0] r;
      case (m)
         MODE_LEVY: r = sat_coord(64'sd375 <<< frac);
         default:   r = sat_coord(64'sd750 <<< frac);
      endcase
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] origin_y(input mode_type m,
                                                             input int frac);
      logic signed [CoordWidth-1:0] r;
      case (m)
         MODE_SIERPINSKI: r = sat_coord(64'sd450 <<< frac);
         default:         r = sat_coord(64'sd225 <<< frac);
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/tsg_front.sv =====
`timescale 1ns / 1ps
module tsg_front #(
   parameter int FRACTION_BITS = tsg_pkg::FractionBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              q_full,
   output logic              q_push,
   output tsg_pkg::step_type q_entry
);
   import tsg_pkg::*;

   mode_type                 mode_ff;
   logic [HeadingWidth-1:0]  heading_ff, heading_in;
   logic                     turned_ff, turned_in;

   // Constant step tables, one row per mode; the unused row stays zero
   logic signed [CoordWidth-1:0] tab_dx [4][HeadingUnits];
   logic signed [CoordWidth-1:0] tab_dy [4][HeadingUnits];

   for (genvar m = 0; m < 4; m++) begin : g_mode
      for (genvar d = 0; d < HeadingUnits; d++) begin : g_dir
         assign tab_dx[m][d] = step_disp(m, d, 1'b0, FRACTION_BITS);
         assign tab_dy[m][d] = step_disp(m, d, 1'b1, FRACTION_BITS);
      end
   end

   logic [HeadingWidth-1:0] h_base, h_left, h_right, turn, dir;
   logic [HeadingWidth:0]   left_sum;
   logic                    t_base, is_left, is_right, is_turn, accept, hold;

   // Drop symbols in mode none, otherwise wait for queue room
   assign req_tready = (mode_ff == MODE_NONE) || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (mode_ff != MODE_NONE);

   // Classify the symbol and work out heading and direction
   always_comb begin
      h_base   = req_tuser ? '0 : heading_ff;
      t_base   = req_tuser ? 1'b0 : turned_ff;
      turn     = turn_units(mode_ff);
      is_left  = (req_tdata == SymTurnLeft);
      is_right = (req_tdata == SymTurnRight);
      is_turn  = is_left || is_right;
      left_sum = {1'b0, h_base} + {1'b0, turn};
      h_left   = (left_sum >= (HeadingWidth+1)'(HeadingUnits))
                 ? HeadingWidth'(left_sum - (HeadingWidth+1)'(HeadingUnits))
                 : HeadingWidth'(left_sum);
      h_right  = (h_base >= turn) ? (h_base - turn)
                 : HeadingWidth'(h_base + HeadingWidth'(HeadingUnits) - turn);
      heading_in = is_left ? h_left : (is_right ? h_right : h_base);
      turned_in  = 1'b0;
      hold       = 1'b0;
      dir        = '0;
      q_entry.emit = 1'b0;
      if (mode_ff == MODE_LEVY) begin
         if (is_turn) begin
            turned_in = 1'b1;
            hold      = 1'b1;
         end else begin
            q_entry.emit = 1'b1;
            dir          = t_base ? h_base : '0;
         end
      end else if (is_turn) begin
         q_entry.emit = 1'b1;
         dir          = heading_in;
      end
      q_entry.restart = req_tuser;
      q_entry.mode    = mode_ff;
      q_entry.dx      = hold ? '0 : tab_dx[mode_ff][dir];
      q_entry.dy      = hold ? '0 : tab_dy[mode_ff][dir];
   end

   // Mode register and turtle heading
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DRAGON;
         heading_ff <= '0;
         turned_ff  <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= mode_type'(csr_wdata);
         if (q_push) begin
            heading_ff <= heading_in;
            turned_ff  <= turned_in;
         end
      end
   end

endmodule

// ===== hdl/tsg_queue.sv =====
`timescale 1ns / 1ps
module tsg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsg_pkg::step_type push_entry,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tsg_pkg::step_type head
);
   import tsg_pkg::*;

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);

   step_type              slot_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == CntWidth'(QueueDepth));
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== hdl/tsg_back.sv =====
`timescale 1ns / 1ps
module tsg_back #(
   parameter int FRACTION_BITS = tsg_pkg::FractionBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tsg_pkg::step_type q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata
);
   import tsg_pkg::*;

   logic signed [CoordWidth-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [CoordWidth-1:0] base_x, base_y;
   logic signed [CoordWidth:0]   sum_x, sum_y;
   logic                         out_valid_ff, out_valid_in;
   logic [127:0]                 out_data_ff;

   // Saturating add of one step to the pen
   function automatic logic signed [CoordWidth-1:0] sat_add(
      input logic signed [CoordWidth:0] s);
      logic signed [CoordWidth-1:0] r;
      if (s[CoordWidth] != s[CoordWidth-1])
         r = s[CoordWidth] ? {1'b1, {(CoordWidth-1){1'b0}}}
                           : {1'b0, {(CoordWidth-1){1'b1}}};
      else
         r = s[CoordWidth-1:0];
      return r;
   endfunction

   // Pop unless a segment would overwrite one still waiting
   assign q_pop = q_valid && (!q_head.emit || !out_valid_ff || rsp_tready);

   always_comb begin
      base_x   = q_head.restart ? origin_x(q_head.mode, FRACTION_BITS) : pen_x_ff;
      base_y   = q_head.restart ? origin_y(q_head.mode, FRACTION_BITS) : pen_y_ff;
      sum_x    = {base_x[CoordWidth-1], base_x} + {q_head.dx[CoordWidth-1], q_head.dx};
      sum_y    = {base_y[CoordWidth-1], base_y} + {q_head.dy[CoordWidth-1], q_head.dy};
      pen_x_in = sat_add(sum_x);
      pen_y_in = sat_add(sum_y);
      out_valid_in = out_valid_ff && !rsp_tready;
      if (q_pop && q_head.emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= origin_x(MODE_DRAGON, FRACTION_BITS);
         pen_y_ff     <= origin_y(MODE_DRAGON, FRACTION_BITS);
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            pen_x_ff <= pen_x_in;
            pen_y_ff <= pen_y_in;
         end
      end
   end

   // Hold the segment beat until taken
   always_ff @(posedge clock) begin
      if (q_pop && q_head.emit) out_data_ff <= {pen_y_in, pen_x_in, base_y, base_x};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== hdl/turtle_segment_generator_top.sv =====
`timescale 1ns / 1ps
// Turtle interpreter for L-system strings, drawing line segments.
// req channel: one symbol per beat. tdata[7:0] is the symbol ('I' turns left,
// 'D' turns right); tuser is string_start, which puts the pen at the origin of
// the current mode with heading zero before the symbol is handled.
// rsp channel: one segment per beat, signed fixed point with FRACTION_BITS
// fraction bits, y downward: tdata holds start_x, start_y, end_x, end_y.
// csr port: csr_we writes the 2-bit mode (dragon, levy, sierpinski, none);
// write it only while the block is idle.
// Throughput is one symbol per cycle while the queue has room. An accepted
// symbol passes through the front (classifies it and looks up the step in a
// constant table), a four-entry queue, then the back end, which adds the step
// to the pen with saturation into the output register. The pen add loop sets
// the rate.
// Reset selects dragon mode, places the pen at the dragon origin and empties
// the queue. When rsp_tready is low the segment holds in its register, the
// queue fills, and req_tready drops once it is full; in mode none every
// symbol is accepted and dropped.
module turtle_segment_generator_top #(
   parameter int FRACTION_BITS = tsg_pkg::FractionBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,   // fractal_mode
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] symbol
   input  logic         req_tuser,   // [0] string_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // start_x, start_y, end_x, end_y from bit 0 up
);
   import tsg_pkg::*;

   logic     q_push, q_full, q_pop, q_valid;
   step_type q_entry, q_head;

   tsg_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   tsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   tsg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
